FILE: design/assert_macros.svh
// assertion macros shared by the blend pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCBM_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define PCBM_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define PCBM_ASSERT_NOW(label, clk, rst_n, a, b)
`define PCBM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: design/pcbm_pkg.sv
// types, mode codes and the interpolation curve table
`default_nettype none
package pcbm_pkg;

	typedef enum logic [4:0] {
		MODE_AVERAGE      = 5'd0,
		MODE_MULTIPLY     = 5'd1,
		MODE_SCREEN       = 5'd2,
		MODE_DARKEN       = 5'd3,
		MODE_LIGHTEN      = 5'd4,
		MODE_DIFFERENCE   = 5'd5,
		MODE_NEGATION     = 5'd6,
		MODE_EXCLUSION    = 5'd7,
		MODE_OVERLAY      = 5'd8,
		MODE_HARD_LIGHT   = 5'd9,
		MODE_SOFT_LIGHT   = 5'd10,
		MODE_COLOR_DODGE  = 5'd11,
		MODE_COLOR_BURN   = 5'd12,
		MODE_SOFT_DODGE   = 5'd13,
		MODE_SOFT_BURN    = 5'd14,
		MODE_REFLECT      = 5'd15,
		MODE_GLOW         = 5'd16,
		MODE_FREEZE       = 5'd17,
		MODE_HEAT         = 5'd18,
		MODE_ADDITIVE     = 5'd19,
		MODE_SUBTRACTIVE  = 5'd20,
		MODE_INTERPOLATE  = 5'd21,
		MODE_STAMP        = 5'd22,
		MODE_XOR          = 5'd23
	} blend_mode_t;

	typedef struct packed {
		logic [15:0] num;
		logic [7:0]  den;
	} pcbm_div_req_t;

	typedef logic [7:0] curve_rom_t [256];

	// 128*sin^2 curve in q2.30, rounded
	function automatic logic [7:0] curve_entry(input int unsigned x);
		logic [63:0] phi;
		logic [63:0] phi2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] sq;
		phi  = (((64'(x) & 64'hFF) * 64'd157 << 30) + 64'd12750) / 64'd25500;
		phi2 = (phi * phi) >> 30;
		term = phi;
		sum  = phi;
		term = ((term * phi2) >> 30) / 64'd6;   sum = sum - term;
		term = ((term * phi2) >> 30) / 64'd20;  sum = sum + term;
		term = ((term * phi2) >> 30) / 64'd42;  sum = sum - term;
		term = ((term * phi2) >> 30) / 64'd72;  sum = sum + term;
		term = ((term * phi2) >> 30) / 64'd110; sum = sum - term;
		term = ((term * phi2) >> 30) / 64'd156; sum = sum + term;
		term = ((term * phi2) >> 30) / 64'd210; sum = sum - term;
		term = ((term * phi2) >> 30) / 64'd272; sum = sum + term;
		term = ((term * phi2) >> 30) / 64'd342; sum = sum - term;
		term = ((term * phi2) >> 30) / 64'd420; sum = sum + term;
		term = ((term * phi2) >> 30) / 64'd506; sum = sum - term;
		term = ((term * phi2) >> 30) / 64'd600; sum = sum + term;
		term = ((term * phi2) >> 30) / 64'd702; sum = sum - term;
		sq = (sum * sum) >> 30;
		return 8'(((sq << 7) + (64'd1 << 29)) >> 30);
	endfunction

	function automatic curve_rom_t build_curve();
		curve_rom_t r;
		for (int i = 0; i < 256; i++) begin
			r[i] = curve_entry(i);
		end
		return r;
	endfunction

	localparam curve_rom_t CURVE_ROM = build_curve();

endpackage
`default_nettype wire

FILE: design/pcbm_div.sv
// two-stage restoring divider, 16 by 8 bits, quotient saturated at 255
`default_nettype none
module pcbm_div (
	input  wire logic                   clk,
	input  wire pcbm_pkg::pcbm_div_req_t req,
	output logic [7:0]                  q_sat
);
	import pcbm_pkg::*;

	logic [7:0] rem_s2;
	logic [3:0] low_s2;
	logic [7:0] den_s2;
	logic [3:0] qhi_s2;
	logic       over_s2;

	logic [7:0] rem_a;
	logic [3:0] q_a;
	logic       over_a;
	logic [8:0] r9_a;

	// upper four quotient bits
	always_comb begin
		rem_a  = req.num[15:8];
		over_a = (req.num[15:8] >= req.den);
		q_a    = '0;
		for (int i = 0; i < 4; i++) begin
			r9_a = {rem_a, req.num[7 - i]};
			if (r9_a >= {1'b0, req.den}) begin
				rem_a       = 8'(r9_a - {1'b0, req.den});
				q_a[3 - i]  = 1'b1;
			end else begin
				rem_a = r9_a[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_s2  <= rem_a;
		low_s2  <= req.num[3:0];
		den_s2  <= req.den;
		qhi_s2  <= q_a;
		over_s2 <= over_a;
	end

	logic [7:0] rem_b;
	logic [3:0] q_b;
	logic [8:0] r9_b;

	// lower four quotient bits
	always_comb begin
		rem_b = rem_s2;
		q_b   = '0;
		for (int i = 0; i < 4; i++) begin
			r9_b = {rem_b, low_s2[3 - i]};
			if (r9_b >= {1'b0, den_s2}) begin
				rem_b      = 8'(r9_b - {1'b0, den_s2});
				q_b[3 - i] = 1'b1;
			end else begin
				rem_b = r9_b[7:0];
			end
		end
		q_sat = over_s2 ? 8'd255 : {qhi_s2, q_b};
	end

endmodule
`default_nettype wire

FILE: design/pixel_channel_blend_modes.sv
// top level: per-channel layer blend pipeline
// usage:
//   write blend_mode through cfg_we/cfg_wdata while no item is in flight.
//   present base_value and blend_value with start; an item is taken at any
//   edge where start is high and busy is low. busy stays low: the pipeline
//   takes one item every cycle.
//   blended_value shows with done for one cycle, once the item has passed
//   the stage 1, stage 2 and stage 3 registers, and is taken while done is high
//   (stage 1 multipliers and divisor setup, stage 2 upper quotient
//   bits and simple modes, stage 3 lower quotient bits and final select).
//   the divider modes set the stage depth; every mode has the same latency.
//   throughput is one item per cycle in every mode.
//   reset clears the stage valid bits and sets the mode to average.
//   the receiver cannot stall; results must be taken when done is high.
`default_nettype none
`include "assert_macros.svh"
module pixel_channel_blend_modes (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] base_value,
	input  wire logic [7:0] blend_value,
	output logic            done,
	output logic [7:0]      blended_value
);
	import pcbm_pkg::*;

	logic [4:0] mode_q;
	logic valid_s1, valid_s2, valid_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_AVERAGE;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: products and divider setup
	logic [7:0]  na, nb, sq_op;
	logic [15:0] ab_c, inv_c, sq_c;
	pcbm_div_req_t req_c;
	logic        dinv_c, force_c;
	logic [7:0]  force_val_c;

	always_comb begin
		na    = ~base_value;
		nb    = ~blend_value;
		sq_op = base_value;
		unique case (mode_q)
			MODE_GLOW:   sq_op = blend_value;
			MODE_FREEZE: sq_op = na;
			MODE_HEAT:   sq_op = nb;
			default:     sq_op = base_value;
		endcase
		ab_c  = 16'(base_value) * 16'(blend_value);
		inv_c = 16'(na) * 16'(nb);
		sq_c  = 16'(sq_op) * 16'(sq_op);
		req_c       = '{num: {base_value, 8'd0}, den: nb};
		dinv_c      = 1'b0;
		force_c     = 1'b0;
		force_val_c = 8'd255;
		unique case (mode_q)
			MODE_COLOR_DODGE: begin
				req_c   = '{num: {base_value, 8'd0}, den: nb};
				force_c = (blend_value == 8'd255);
			end
			MODE_COLOR_BURN: begin
				req_c       = '{num: {na, 8'd0}, den: blend_value};
				dinv_c      = 1'b1;
				force_c     = (blend_value == 8'd0);
				force_val_c = 8'd0;
			end
			MODE_SOFT_DODGE: begin
				force_c = (blend_value == 8'd255);
				if ({1'b0, base_value} + {1'b0, blend_value} < 9'd256) begin
					req_c = '{num: {1'b0, base_value, 7'd0}, den: nb};
				end else begin
					req_c  = '{num: {1'b0, nb, 7'd0}, den: base_value};
					dinv_c = 1'b1;
				end
			end
			MODE_SOFT_BURN: begin
				force_c = (base_value == 8'd255);
				if ({1'b0, base_value} + {1'b0, blend_value} < 9'd256) begin
					req_c = '{num: {1'b0, blend_value, 7'd0}, den: na};
				end else begin
					req_c  = '{num: {1'b0, na, 7'd0}, den: blend_value};
					dinv_c = 1'b1;
				end
			end
			MODE_REFLECT: begin
				req_c   = '{num: sq_c, den: nb};
				force_c = (blend_value == 8'd255);
			end
			MODE_GLOW: begin
				req_c   = '{num: sq_c, den: na};
				force_c = (base_value == 8'd255);
			end
			MODE_FREEZE: begin
				req_c       = '{num: sq_c, den: blend_value};
				dinv_c      = 1'b1;
				force_c     = (blend_value == 8'd0);
				force_val_c = 8'd0;
			end
			MODE_HEAT: begin
				req_c       = '{num: sq_c, den: base_value};
				dinv_c      = 1'b1;
				force_c     = (base_value == 8'd0);
				force_val_c = 8'd0;
			end
			default: begin
				req_c = '{num: {base_value, 8'd0}, den: nb};
			end
		endcase
	end

	logic [7:0]    a_s1, b_s1;
	logic [4:0]    mode_s1;
	logic [15:0]   ab_s1, inv_s1;
	pcbm_div_req_t req_s1;
	logic          dinv_s1, force_s1;
	logic [7:0]    force_val_s1;

	always_ff @(posedge clk) begin
		a_s1         <= base_value;
		b_s1         <= blend_value;
		mode_s1      <= mode_q;
		ab_s1        <= ab_c;
		inv_s1       <= inv_c;
		req_s1       <= req_c;
		dinv_s1      <= dinv_c;
		force_s1     <= force_c;
		force_val_s1 <= force_val_c;
	end

	// stage 2: divider upper quotient bits, simple modes, soft light product
	logic [7:0]  q_sat;

	pcbm_div u_div (
		.clk   (clk),
		.req   (req_s1),
		.q_sat (q_sat)
	);

	logic [7:0]  misc_c, t_c, scr_c, diff_c, cva, cvb;
	logic [8:0]  sum9, csum;
	logic [9:0]  stamp10, excl10;
	logic [15:0] p2_c;
	logic        is_div_c, soft_c;

	always_comb begin
		t_c     = ab_s1[15:8];
		scr_c   = ~inv_s1[15:8];
		diff_c  = scr_c - t_c;
		p2_c    = 16'(a_s1) * 16'(diff_c);
		sum9    = {1'b0, a_s1} + {1'b0, b_s1};
		cva     = CURVE_ROM[a_s1];
		cvb     = CURVE_ROM[b_s1];
		csum    = {1'b0, cva} + {1'b0, cvb};
		stamp10 = {2'b0, a_s1} + {1'b0, b_s1, 1'b0};
		excl10  = {1'b0, sum9} - {1'b0, ab_s1[15:7]};
		is_div_c = 1'b0;
		soft_c   = 1'b0;
		misc_c   = a_s1;
		unique case (mode_s1)
			MODE_AVERAGE:    misc_c = sum9[8:1];
			MODE_MULTIPLY:   misc_c = ab_s1[15:8];
			MODE_SCREEN:     misc_c = ~inv_s1[15:8];
			MODE_DARKEN:     misc_c = (a_s1 < b_s1) ? a_s1 : b_s1;
			MODE_LIGHTEN:    misc_c = (a_s1 > b_s1) ? a_s1 : b_s1;
			MODE_DIFFERENCE: misc_c = (a_s1 > b_s1) ? a_s1 - b_s1 : b_s1 - a_s1;
			MODE_NEGATION:   misc_c = ~((a_s1 > b_s1) ? a_s1 - b_s1 : b_s1 - a_s1);
			MODE_EXCLUSION:  misc_c = excl10[7:0];
			MODE_OVERLAY:    misc_c = a_s1[7] ? 8'(~inv_s1[14:7]) : ab_s1[14:7];
			MODE_HARD_LIGHT: misc_c = b_s1[7] ? 8'(~inv_s1[14:7]) : ab_s1[14:7];
			MODE_SOFT_LIGHT: soft_c = 1'b1;
			MODE_COLOR_DODGE, MODE_COLOR_BURN, MODE_SOFT_DODGE, MODE_SOFT_BURN,
			MODE_REFLECT, MODE_GLOW, MODE_FREEZE, MODE_HEAT: is_div_c = 1'b1;
			MODE_ADDITIVE:    misc_c = sum9[8] ? 8'd255 : sum9[7:0];
			MODE_SUBTRACTIVE: misc_c = sum9[8] ? sum9[7:0] : 8'd0;
			MODE_INTERPOLATE: misc_c = csum[8] ? 8'd255 : csum[7:0];
			MODE_STAMP: begin
				if (stamp10 < 10'd256) begin
					misc_c = 8'd0;
				end else if (stamp10 >= 10'd512) begin
					misc_c = 8'd255;
				end else begin
					misc_c = stamp10[7:0];
				end
			end
			MODE_XOR:        misc_c = a_s1 ^ b_s1;
			default:         misc_c = a_s1;
		endcase
	end

	logic [7:0]  misc_s2, t_s2, force_val_s2;
	logic [15:0] p2_s2;
	logic        is_div_s2, soft_s2, dinv_s2, force_s2;

	always_ff @(posedge clk) begin
		misc_s2      <= misc_c;
		t_s2         <= t_c;
		p2_s2        <= p2_c;
		is_div_s2    <= is_div_c;
		soft_s2      <= soft_c;
		dinv_s2      <= dinv_s1;
		force_s2     <= force_s1;
		force_val_s2 <= force_val_s1;
	end

	// stage 3: final select
	logic [7:0] final_c;
	logic [7:0] blended_s3;

	always_comb begin
		priority if (is_div_s2 && force_s2) begin
			final_c = force_val_s2;
		end else if (is_div_s2) begin
			final_c = dinv_s2 ? ~q_sat : q_sat;
		end else if (soft_s2) begin
			final_c = t_s2 + p2_s2[15:8];
		end else begin
			final_c = misc_s2;
		end
	end

	always_ff @(posedge clk) begin
		blended_s3 <= final_c;
	end

	assign done          = valid_s3;
	assign blended_value = blended_s3;

	`PCBM_ASSERT_NEXT(a_accept_s1, clk, arst_n, start && !busy, valid_s1)
	`PCBM_ASSERT_NEXT(a_s1_s2, clk, arst_n, valid_s1, valid_s2)
	`PCBM_ASSERT_NEXT(a_s2_done, clk, arst_n, valid_s2, done)
	`PCBM_ASSERT_NOW(a_done_src, clk, arst_n, done, $past(valid_s2))
	`PCBM_ASSERT_NOW(a_never_busy, clk, arst_n, 1'b1, !busy)

endmodule
`default_nettype wire
